// ----- hdl/utce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTCTime converter package
// Shared payload types, status codes and calendar constants for the UTCTime
// string to epoch seconds converter.
// ----------------------------------------------------------------------------
package utce_pkg;

   // Request payload: one character of the string
   typedef struct packed {
      logic [7:0] text_char;
      logic       is_last;
   } req_type;

   // Response payload: epoch seconds and status
   typedef struct packed {
      logic signed [32:0] epoch_seconds;
      logic [1:0]         status;
   } rsp_type;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEN   = 2'd1;
   localparam logic [1:0] STATUS_NO_ZULU   = 2'd2;
   localparam logic [1:0] STATUS_BAD_DIGIT = 2'd3;

   // Characters
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_ZULU = 8'h5A;

   // String layout: twelve digits, then 'Z'
   localparam logic [3:0] DIGIT_COUNT = 4'd12;
   localparam logic [3:0] COUNT_MAX   = 4'd15;
   localparam int         FIELD_COUNT = 6;
   localparam logic [6:0] PIVOT_RESET = 7'd50;

   // Field slots in the order they arrive
   localparam int SLOT_YEAR   = 0;
   localparam int SLOT_MONTH  = 1;
   localparam int SLOT_DAY    = 2;
   localparam int SLOT_HOUR   = 3;
   localparam int SLOT_MINUTE = 4;
   localparam int SLOT_SECOND = 5;

   // Years are carried as an offset from 1899
   localparam logic [7:0] OFS_19XX = 8'd1;
   localparam logic [7:0] OFS_20XX = 8'd101;
   localparam logic [7:0] OFS_1900 = 8'd1;
   localparam logic [7:0] OFS_1901 = 8'd2;
   localparam logic [7:0] OFS_2100 = 8'd201;
   localparam logic [7:0] OFS_2101 = 8'd202;

   // Days from 1899-01-01 to 1970-01-01, plus one for the 1-based day
   localparam logic signed [17:0] EPOCH_DAY_BIAS = 18'sd25933;
   localparam logic [3:0]         MONTH_DEC      = 4'd11;
   localparam logic [3:0]         MONTH_MAR      = 4'd2;

   localparam logic signed [35:0] SECS_PER_DAY = 36'sd86400;
   localparam logic signed [35:0] EPOCH_MAX    = 36'sd4294967295;
   localparam logic signed [32:0] EPOCH_ERROR  = -33'sd1;

   // Job passed from the front end to the arithmetic back end
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] year_ofs;
      logic [6:0] month;
      logic [6:0] day;
      logic [6:0] hour;
      logic [6:0] minute;
      logic [6:0] second;
   } job_type;

   // Days before the first of a month (0-based month) in a common year
   function automatic logic [8:0] month_start_days(input logic [3:0] mon);
      logic [8:0] days;
      case (mon)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ----- hdl/utce_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTCTime front end
// Counts characters, folds digit pairs into two-digit fields, checks the
// string shape and hands one job per string to the queue.
// ----------------------------------------------------------------------------
module utce_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [6:0]        csr_write_data,
   input  logic              accept,
   input  utce_pkg::req_type req_data,
   output logic              push,
   output utce_pkg::job_type job
);

   logic [6:0] pivot_ff;
   logic [3:0] count_ff, count_in;
   logic [3:0] tens_ff, tens_in;
   logic [6:0] field_ff [utce_pkg::FIELD_COUNT];
   logic [6:0] field_in [utce_pkg::FIELD_COUNT];
   logic       bad_ff, bad_in;

   logic       is_digit;
   logic [7:0] char_diff;
   logic [3:0] digit;
   logic [6:0] pair;
   logic [2:0] slot;
   logic [6:0] year;

   // Digit decode
   assign is_digit  = (req_data.text_char >= utce_pkg::CHAR_ZERO) &&
                      (req_data.text_char <= utce_pkg::CHAR_NINE);
   assign char_diff = req_data.text_char - utce_pkg::CHAR_ZERO;
   assign digit     = is_digit ? char_diff[3:0] : 4'd0;
   assign pair      = {3'b000, tens_ff} * 7'd10 + {3'b000, digit};
   assign slot      = count_ff[3:1];

   // Next state for count, digits and fields
   always_comb begin
      count_in = count_ff;
      tens_in  = tens_ff;
      bad_in   = bad_ff;
      for (int i = 0; i < utce_pkg::FIELD_COUNT; i++) begin
         field_in[i] = field_ff[i];
      end
      if (accept && req_data.is_last) begin
         // end of string: start over for the next one
         count_in = 4'd0;
         tens_in  = 4'd0;
         bad_in   = 1'b0;
         for (int i = 0; i < utce_pkg::FIELD_COUNT; i++) begin
            field_in[i] = 7'd0;
         end
      end else if (accept) begin
         if (count_ff < utce_pkg::DIGIT_COUNT) begin
            if (!is_digit) begin
               bad_in = 1'b1;
            end
            if (!count_ff[0]) begin
               tens_in = digit;
            end else begin
               field_in[slot] = pair;
            end
         end
         if (count_ff != utce_pkg::COUNT_MAX) begin
            count_in = count_ff + 4'd1;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_ff <= utce_pkg::PIVOT_RESET;
         count_ff <= 4'd0;
         tens_ff  <= 4'd0;
         bad_ff   <= 1'b0;
         for (int i = 0; i < utce_pkg::FIELD_COUNT; i++) begin
            field_ff[i] <= 7'd0;
         end
      end else begin
         if (csr_write_enable) begin
            pivot_ff <= csr_write_data;
         end
         count_ff <= count_in;
         tens_ff  <= tens_in;
         bad_ff   <= bad_in;
         for (int i = 0; i < utce_pkg::FIELD_COUNT; i++) begin
            field_ff[i] <= field_in[i];
         end
      end
   end

   // Job built from the stored fields on the last character
   assign push = accept && req_data.is_last;
   assign year = field_ff[utce_pkg::SLOT_YEAR];

   always_comb begin
      if (count_ff != utce_pkg::DIGIT_COUNT) begin
         job.status = utce_pkg::STATUS_BAD_LEN;
      end else if (req_data.text_char != utce_pkg::CHAR_ZULU) begin
         job.status = utce_pkg::STATUS_NO_ZULU;
      end else if (bad_ff) begin
         job.status = utce_pkg::STATUS_BAD_DIGIT;
      end else begin
         job.status = utce_pkg::STATUS_OK;
      end
      job.year_ofs = (year < pivot_ff) ? {1'b0, year} + utce_pkg::OFS_20XX
                                       : {1'b0, year} + utce_pkg::OFS_19XX;
      job.month    = field_ff[utce_pkg::SLOT_MONTH];
      job.day      = field_ff[utce_pkg::SLOT_DAY];
      job.hour     = field_ff[utce_pkg::SLOT_HOUR];
      job.minute   = field_ff[utce_pkg::SLOT_MINUTE];
      job.second   = field_ff[utce_pkg::SLOT_SECOND];
   end

endmodule

// ----- hdl/utce_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTCTime job queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module utce_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  utce_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output utce_pkg::job_type head_data
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   utce_pkg::job_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/utce_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTCTime back end
// Four-stage pipeline: month carry and time of day, day count, scaling to
// seconds, then the final sum, clamp and response register.
// ----------------------------------------------------------------------------
module utce_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  utce_pkg::job_type head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output utce_pkg::rsp_type rsp_data
);

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  year_ofs;
      logic [3:0]  mon;
      logic [6:0]  day;
      logic [18:0] hms;
   } stage1_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [17:0] days;
      logic [18:0]        hms;
   } stage2_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [35:0] day_secs;
      logic [18:0]        hms;
   } stage3_type;

   logic       s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   stage1_type s1_ff, s1_in;
   stage2_type s2_ff, s2_in;
   stage3_type s3_ff, s3_in;
   utce_pkg::rsp_type out_ff, out_in;
   logic       s1_ready, s2_ready, s3_ready, out_ready;

   // Stall chain: a stage moves when the next one is free or moving
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign pop       = head_valid && s1_ready;

   // Stage 1: carry months into years, time of day in seconds
   logic [6:0]  mon_m1;
   logic [12:0] recip;
   logic [3:0]  quo;
   logic [6:0]  rem;

   assign mon_m1 = head_data.month - 7'd1;
   assign recip  = {6'b0, mon_m1} * 13'd43;      // about x/12 for x below 99
   assign quo    = recip[12:9];
   assign rem    = mon_m1 - {3'b000, quo} * 7'd12;

   always_comb begin
      s1_in.status = head_data.status;
      s1_in.day    = head_data.day;
      if (head_data.month == 7'd0) begin
         // month zero is December of the year before
         s1_in.year_ofs = head_data.year_ofs - 8'd1;
         s1_in.mon      = utce_pkg::MONTH_DEC;
      end else begin
         s1_in.year_ofs = head_data.year_ofs + {4'b0000, quo};
         s1_in.mon      = rem[3:0];
      end
      s1_in.hms = {12'b0, head_data.hour} * 19'd3600
                + {12'b0, head_data.minute} * 19'd60
                + {12'b0, head_data.second};
   end

   // Stage 2: days since the epoch
   logic [7:0]  n_ofs;
   logic [8:0]  n_plus2;
   logic [6:0]  leaps;
   logic        leap_year;
   logic        leap_adj;
   logic [16:0] day_sum;

   assign n_ofs     = s1_ff.year_ofs;
   assign n_plus2   = {1'b0, n_ofs} + 9'd2;
   assign leaps     = n_plus2[8:2]
                    - {6'b0, (n_ofs >= utce_pkg::OFS_1901)}
                    - {6'b0, (n_ofs >= utce_pkg::OFS_2101)};
   // year is 1899 + offset: divisible by four when the offset ends in 01
   assign leap_year = (n_ofs[1:0] == 2'b01) && (n_ofs != utce_pkg::OFS_1900) &&
                      (n_ofs != utce_pkg::OFS_2100);
   assign leap_adj  = leap_year && (s1_ff.mon >= utce_pkg::MONTH_MAR);
   assign day_sum   = {9'b0, n_ofs} * 17'd365 + {10'b0, leaps}
                    + {8'b0, utce_pkg::month_start_days(s1_ff.mon)}
                    + {16'b0, leap_adj} + {10'b0, s1_ff.day};

   always_comb begin
      s2_in.status = s1_ff.status;
      s2_in.hms    = s1_ff.hms;
      s2_in.days   = $signed({1'b0, day_sum}) - utce_pkg::EPOCH_DAY_BIAS;
   end

   // Stage 3: days to seconds
   logic signed [35:0] days_ext;

   assign days_ext = 36'(s2_ff.days);

   always_comb begin
      s3_in.status   = s2_ff.status;
      s3_in.hms      = s2_ff.hms;
      s3_in.day_secs = days_ext * utce_pkg::SECS_PER_DAY;
   end

   // Stage 4: add time of day, clamp, error value
   logic signed [35:0] total;

   assign total = s3_ff.day_secs + $signed({17'b0, s3_ff.hms});

   always_comb begin
      out_in.status = s3_ff.status;
      if (s3_ff.status != utce_pkg::STATUS_OK) begin
         out_in.epoch_seconds = utce_pkg::EPOCH_ERROR;
      end else if (total > utce_pkg::EPOCH_MAX) begin
         out_in.epoch_seconds = utce_pkg::EPOCH_MAX[32:0];
      end else begin
         out_in.epoch_seconds = total[32:0];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= head_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
      if (s3_ready) begin
         s3_ff <= s3_in;
      end
      if (out_ready) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- hdl/utctime_to_epoch_seconds.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTCTime to epoch seconds
// Takes YYMMDDhhmmssZ one character per request and returns signed UTC epoch
// seconds, or -1 with a status, once per string.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle; req_stall rises only when the job
//   queue between front and back end is full (QUEUE_DEPTH strings waiting).
// Path: after the last character is accepted, the job passes through the
//   queue, then the three-stage back end and its output register.
// Reset: synchronous; clears the character count, fields, queue and
//   pipeline, and loads the century pivot with 50.
module utctime_to_epoch_seconds #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  utce_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output utce_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [6:0]        csr_write_data
);

   logic              req_accept;
   logic              push;
   logic              queue_full;
   logic              pop;
   logic              head_valid;
   utce_pkg::job_type push_job;
   utce_pkg::job_type head_job;

   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // Character parsing and checks
   utce_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (req_accept),
      .req_data         (req_data),
      .push             (push),
      .job              (push_job)
   );

   // Job queue
   utce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_job)
   );

   // Calendar arithmetic
   utce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // A job is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !queue_full)
      else $error("job pushed into full queue");

   // A finished string leaves a job waiting in the queue next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.is_last) |=> head_valid)
      else $error("last character accepted but queue empty");

   // Failed strings always carry -1
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != utce_pkg::STATUS_OK)) |->
      (rsp_data.epoch_seconds == utce_pkg::EPOCH_ERROR))
      else $error("error response without -1");

endmodule

// ----- sim/utce_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTCTime converter checker
// Watches the request, response and CSR ports of the converter and keeps its
// own copy of the pivot and the string being parsed. Each string it sees
// ending gives one predicted response. Each accepted response is compared
// with the oldest prediction. Errors and the number of outstanding
// responses go to the testbench top.
// ----------------------------------------------------------------------------
module utce_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  utce_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  utce_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [6:0]        csr_write_data,
   output int                error_count,
   output int                pending_count,
   output int                checked_count
);
   import utce_pkg::*;

   logic [6:0] pivot;
   logic [3:0] char_count;
   logic [3:0] tens;
   logic [6:0] field [FIELD_COUNT];
   logic       bad_digit;
   rsp_type    pending_times [$];
   int         errors;
   int         checked;

   // UTC seconds for two-digit fields, carrying out-of-range values like timegm
   function automatic logic signed [32:0] utc_seconds(
      input logic [6:0] yy, mm, dd, hh, mi, ss,
      input logic [6:0] yy_pivot
   );
      longint year, mon, era, yoe, doy, doe, days, secs;
      year = longint'(yy) + ((yy < yy_pivot) ? 64'sd2000 : 64'sd1900);
      mon  = longint'(mm) - 1;
      if (mon < 0) begin
         year -= 1;
         mon  += 12;
      end else begin
         year += mon / 12;
         mon   = mon % 12;
      end
      // day count of the first of the month, years starting in March
      if (mon < 2) year -= 1;
      era  = year / 400;
      yoe  = year - era * 400;
      doy  = (153 * ((mon >= 2) ? mon - 2 : mon + 10) + 2) / 5;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468 + longint'(dd) - 1;
      secs = days * 86400 + longint'(hh) * 3600 + longint'(mi) * 60 + longint'(ss);
      if (secs > EPOCH_MAX) secs = EPOCH_MAX;
      return secs[32:0];
   endfunction

   task clear_string();
      char_count = '0;
      tens       = '0;
      bad_digit  = 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) field[i] = '0;
   endtask

   always @(posedge clock) begin : track
      rsp_type            want;
      logic [3:0]         digit;
      logic [1:0]         code;
      logic signed [32:0] secs;
      logic               is_digit;
      if (reset) begin
         pivot = PIVOT_RESET;
         clear_string();
         pending_times.delete();
         errors  = 0;
         checked = 0;
      end else begin
         if (csr_write_enable) pivot = csr_write_data;

         // response side: compare against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_times.size() == 0) begin
               $error("unexpected response: epoch_seconds %0d status %0d",
                      rsp_data.epoch_seconds, rsp_data.status);
               errors++;
            end else begin
               want = pending_times.pop_front();
               checked++;
               if (rsp_data.epoch_seconds !== want.epoch_seconds) begin
                  $error("epoch_seconds mismatch: expected %0d, actual %0d",
                         want.epoch_seconds, rsp_data.epoch_seconds);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_data.status);
                  errors++;
               end
            end
         end

         // request side: fold digits, predict on the last character
         if (req_valid && !req_stall) begin
            if (!req_data.is_last) begin
               if (char_count < DIGIT_COUNT) begin
                  is_digit = (req_data.text_char >= CHAR_ZERO) &&
                             (req_data.text_char <= CHAR_NINE);
                  digit    = is_digit ? 4'(req_data.text_char - CHAR_ZERO) : 4'd0;
                  if (!is_digit) bad_digit = 1'b1;
                  if (!char_count[0]) tens = digit;
                  else field[char_count[3:1]] = 7'(tens) * 7'd10 + 7'(digit);
               end
               if (char_count != COUNT_MAX) char_count++;
            end else begin
               if (char_count != DIGIT_COUNT) code = STATUS_BAD_LEN;
               else if (req_data.text_char != CHAR_ZULU) code = STATUS_NO_ZULU;
               else if (bad_digit) code = STATUS_BAD_DIGIT;
               else code = STATUS_OK;
               if (code == STATUS_OK) begin
                  secs = utc_seconds(field[SLOT_YEAR], field[SLOT_MONTH], field[SLOT_DAY],
                                     field[SLOT_HOUR], field[SLOT_MINUTE],
                                     field[SLOT_SECOND], pivot);
               end else begin
                  secs = EPOCH_ERROR;
               end
               want.epoch_seconds = secs;
               want.status        = code;
               pending_times.push_back(want);
               clear_string();
            end
         end
      end
      error_count   <= errors;
      pending_count <= pending_times.size();
      checked_count <= checked;
   end

endmodule

// ----- sim/utctime_to_epoch_seconds_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTCTime to epoch seconds testbench
// Sends directed UTCTime strings (calendar edges, pivot boundary, each error
// status, overlong and Z-only strings, saturation), then random strings of
// every kind over several century pivots, with random idling on both sides.
// A checker module predicts and compares every response.
// ----------------------------------------------------------------------------
module utctime_to_epoch_seconds_tb;
   import utce_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_CHARS  = 265;
   localparam int PHASE_COUNT  = 6;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   req_type    req_data         = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [6:0] csr_write_data   = '0;

   int         error_count;
   int         pending_count;
   int         checked_count;
   int         cycle_count      = 0;
   int         chars_sent       = 0;
   int         strings_sent     = 0;
   int         pivot_writes     = 0;
   bit         calm             = 1'b0;
   logic [7:0] text_q [$];

   utctime_to_epoch_seconds dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   utce_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response backpressure, off during the calm phase
   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 18);
   end

   // one character request, with an optional idle gap in front
   task automatic send_char(input logic [7:0] c, input logic last);
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{text_char: c, is_last: last};
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   task automatic play_text();
      for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
      strings_sent++;
      text_q.delete();
   endtask

   task automatic load_text(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // stop sending and wait out every outstanding response
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_pivot(input logic [6:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pivot_writes++;
   endtask

   function automatic int pick_field(input int lo, input int hi);
      return ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(hi, lo);
   endfunction

   function automatic void add_pair(input int value);
      text_q.push_back(8'(CHAR_ZERO + value / 10));
      text_q.push_back(8'(CHAR_ZERO + value % 10));
   endfunction

   function automatic logic [7:0] non_digit();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
      return c;
   endfunction

   // random string: mostly well formed, then bad digits, bad ending,
   // wrong length and raw noise
   task automatic build_random_string();
      int         kind;
      int         len;
      logic [7:0] c;
      text_q.delete();
      kind = $urandom_range(99);
      if (kind >= 94) begin
         repeat (13) text_q.push_back(8'($urandom_range(255)));
      end else if (kind >= 86) begin
         do len = $urandom_range(21, 1); while (len == 13);
         repeat (len) begin
            if ($urandom_range(3) == 0) text_q.push_back(8'($urandom_range(255)));
            else text_q.push_back(8'(CHAR_ZERO + $urandom_range(9)));
         end
         if ($urandom_range(1)) text_q[len - 1] = CHAR_ZULU;
      end else begin
         add_pair($urandom_range(99));
         add_pair(pick_field(1, 12));
         add_pair(pick_field(1, 31));
         add_pair(pick_field(0, 23));
         add_pair(pick_field(0, 59));
         add_pair(pick_field(0, 60));
         text_q.push_back(CHAR_ZULU);
         if (kind >= 78) begin
            do c = 8'($urandom_range(255)); while (c == CHAR_ZULU);
            text_q[12] = c;
         end else if (kind >= 70) begin
            text_q[$urandom_range(11)] = non_digit();
         end
      end
   endtask

   initial begin : stimulus
      logic [6:0] pivots [PHASE_COUNT];
      int         phase_end;
      pivots = '{7'd0, 7'd99, 7'd127, 7'd1, 7'($urandom_range(127)), PIVOT_RESET};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed strings under the reset pivot
      load_text("491231235959Z"); play_text();
      load_text("500101000000Z"); play_text();
      load_text("700101000000Z"); play_text();
      load_text("000229120000Z"); play_text();
      load_text("000001000000Z"); play_text();
      load_text("991399999999Z"); play_text();
      load_text("700101000000X"); play_text();
      // missing Z outranks the non-digit
      load_text("7x0101000000Q"); play_text();
      load_text("7/0101000:00Z"); play_text();
      load_text("70010100000Z");  play_text();
      load_text("Z");             play_text();
      load_text("7001010000001234Z"); play_text();
      load_text("700101000000Z");
      text_q[2] = 8'h00;
      text_q[5] = 8'hFF;
      play_text();
      load_text("7001Z");
      text_q[4] = 8'hFF;
      play_text();

      // every year is 20yy; far future saturates
      drain();
      write_pivot(7'd127);
      load_text("999901000000Z"); play_text();
      load_text("999999999999Z"); play_text();
      load_text("990101000000Z"); play_text();

      // every year is 19yy; earliest dates
      drain();
      write_pivot(7'd0);
      load_text("000101000000Z"); play_text();
      load_text("000001000000Z"); play_text();

      // random phases, one pivot each, one phase with no idling at all
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         write_pivot(pivots[phase]);
         calm <= (phase == 3);
         phase_end = chars_sent + PHASE_CHARS;
         while (chars_sent < phase_end) begin
            build_random_string();
            play_text();
         end
      end

      drain();
      $display("Checked %0d responses from %0d strings (%0d characters), %0d pivot writes.",
               checked_count, strings_sent, chars_sent, pivot_writes);
      $display("Strings covered valid times, each error status, odd lengths and pivots 0..127.");
      if (error_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
